// ----- hw/rtl/tlsf_pkg.sv -----
// ----------------------------------------------------------------------------
// tlsf_pkg: shared types and helpers of the two-level segregated-fit allocator
// sizes, class mapping, bit scans and the block header layout
// ----------------------------------------------------------------------------
package tlsf_pkg;

    localparam int HEAP_LOG2     = 16;
    localparam int SL_LOG2       = 5;
    localparam int HEADER_BYTES  = 16;
    localparam int GRANULE_BYTES = 8;

    localparam int GRAN_LOG2  = $clog2(GRANULE_BYTES);
    localparam int SPAN       = ((HEADER_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES)
                                * GRANULE_BYTES;
    localparam int NBLK       = (1 << HEAP_LOG2) / GRANULE_BYTES;
    localparam int IDX_W      = HEAP_LOG2 - GRAN_LOG2;
    localparam int SIZE_W     = HEAP_LOG2;
    localparam int FL_COUNT   = HEAP_LOG2 + 1;
    localparam int SL_COUNT   = 1 << SL_LOG2;
    localparam int OFF_W      = 16;
    localparam int B_W        = OFF_W + 1;
    localparam int FL_W       = $clog2(B_W);
    localparam int HEAD_DEPTH = FL_COUNT * SL_COUNT;
    localparam int HEAD_AW    = $clog2(HEAD_DEPTH);
    localparam int THR_W      = 13;
    localparam int THR_RESET  = 32;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ZERO    = 2'd1,
        ST_OOM     = 2'd2,
        ST_BADFREE = 2'd3
    } t_status;

    typedef struct packed {
        logic [FL_W-1:0]    fl;
        logic [SL_LOG2-1:0] sl;
    } t_cls;

    typedef struct packed {
        logic              valid;
        logic              is_free;
        logic              is_last;
        logic              has_prev_phys;
        logic              has_next_free;
        logic              has_prev_free;
        logic [SIZE_W-1:0] size;
        logic [IDX_W-1:0]  prev_phys;
        logic [IDX_W-1:0]  next_free;
        logic [IDX_W-1:0]  prev_free;
    } t_hdr;

    localparam int HDR_W = $bits(t_hdr);

    function automatic logic [FL_W-1:0] top_bit(input logic [B_W-1:0] v);
        logic [FL_W-1:0] n;
        n = '0;
        for (int i = 0; i < B_W; i++) begin
            if (v[i]) n = FL_W'(i);
        end
        return n;
    endfunction

    function automatic t_cls map_size(input logic [B_W-1:0] s);
        logic [FL_W-1:0] t;
        logic [B_W-1:0]  sh;
        t_cls            c;
        t  = top_bit(s);
        sh = '0;
        if (s < B_W'(SL_COUNT)) begin
            c.fl = '0;
            c.sl = SL_LOG2'(s);
        end else begin
            sh   = s >> (t - FL_W'(SL_LOG2));
            c.fl = t;
            c.sl = sh[SL_LOG2-1:0];
        end
        return c;
    endfunction

    function automatic logic [SL_LOG2-1:0] low_bit_sl(input logic [SL_COUNT-1:0] v);
        logic [SL_LOG2-1:0] n;
        n = '0;
        for (int i = SL_COUNT - 1; i >= 0; i--) begin
            if (v[i]) n = SL_LOG2'(i);
        end
        return n;
    endfunction

    function automatic logic [FL_W-1:0] low_bit_fl(input logic [FL_COUNT-1:0] v);
        logic [FL_W-1:0] n;
        n = '0;
        for (int i = FL_COUNT - 1; i >= 0; i--) begin
            if (v[i]) n = FL_W'(i);
        end
        return n;
    endfunction

    function automatic logic [HEAD_AW-1:0] head_addr(input t_cls c);
        return HEAD_AW'({c.fl, c.sl});
    endfunction

    function automatic logic [IDX_W-1:0] phys_succ(input logic [IDX_W-1:0] idx,
                                                   input logic [SIZE_W-1:0] size);
        logic [SIZE_W:0] sum;
        sum = {1'b0, size} + (SIZE_W+1)'(SPAN);
        return idx + IDX_W'(sum >> GRAN_LOG2);
    endfunction

    localparam t_cls INIT_CLS = map_size(B_W'(NBLK * GRANULE_BYTES - SPAN));

endpackage

// ----- hw/rtl/tlsf_ram.sv -----
// ----------------------------------------------------------------------------
// tlsf_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module tlsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/tlsf_heap_allocator.sv -----
// allocate and free: the time from acceptance to result valid is set by the chain of
//   header and list-head ram read-modify-writes
// throughput: one word at a time; the next word is taken the cycle after the result is
//   queued, and a result still waiting in the output register holds off the queueing
// reset: synchronous, active low; afterwards a clearing pass over all 8192 header entries
//   (one entry per cycle) runs before the first word is accepted
// ----------------------------------------------------------------------------
// tlsf_heap_allocator: two-level segregated-fit heap allocator
// block headers and free-list heads live in rams, occupancy bitmaps in flops
// ----------------------------------------------------------------------------
module tlsf_heap_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // request_size[15:0], block_offset[31:16]
    input  logic        i_s_axis_tuser,   // command[0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // payload_offset[15:0], status[17:16], zero
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    localparam int NS = 34;

    typedef enum logic [NS-1:0] {
        S_CLEAR   = NS'(1) << 0,
        S_IDLE    = NS'(1) << 1,
        S_A_ROUND = NS'(1) << 2,
        S_A_CLASS = NS'(1) << 3,
        S_A_MAP   = NS'(1) << 4,
        S_A_SRCH1 = NS'(1) << 5,
        S_A_SRCH2 = NS'(1) << 6,
        S_A_HEAD  = NS'(1) << 7,
        S_A_HWAIT = NS'(1) << 8,
        S_A_HDR   = NS'(1) << 9,
        S_A_SPLIT = NS'(1) << 10,
        S_A_DONE  = NS'(1) << 11,
        S_F_HDR   = NS'(1) << 12,
        S_F_PHDR  = NS'(1) << 13,
        S_F_PMRG  = NS'(1) << 14,
        S_F_PZERO = NS'(1) << 15,
        S_F_NXT   = NS'(1) << 16,
        S_F_NHDR  = NS'(1) << 17,
        S_F_NMRG  = NS'(1) << 18,
        S_F_NZERO = NS'(1) << 19,
        S_F_LINK  = NS'(1) << 20,
        S_U_HEAD  = NS'(1) << 21,
        S_U_HCHK  = NS'(1) << 22,
        S_U_NWR   = NS'(1) << 23,
        S_U_PWR   = NS'(1) << 24,
        S_U_END   = NS'(1) << 25,
        S_L_HEAD  = NS'(1) << 26,
        S_L_HCHK  = NS'(1) << 27,
        S_L_NWR   = NS'(1) << 28,
        S_L_WR    = NS'(1) << 29,
        S_P_RD    = NS'(1) << 30,
        S_P_WR    = NS'(1) << 31,
        S_RESP    = NS'(1) << 32,
        S_SPARE   = NS'(1) << 33
    } t_state;

    t_state r_state, n_state, r_ret, n_ret, r_pret, n_pret;

    logic [tlsf_pkg::IDX_W-1:0]    r_clr, n_clr;
    logic [tlsf_pkg::THR_W-1:0]    r_thr;
    logic [tlsf_pkg::OFF_W-1:0]    r_req, n_req;
    logic [tlsf_pkg::B_W-1:0]      r_b, n_b;
    tlsf_pkg::t_cls                r_cls, n_cls;
    logic [tlsf_pkg::FL_W-1:0]     r_f, n_f;
    logic [tlsf_pkg::SL_LOG2-1:0]  r_s, n_s;
    tlsf_pkg::t_hdr                r_cur, n_cur, r_aux, n_aux;
    logic [tlsf_pkg::IDX_W-1:0]    r_cur_idx, n_cur_idx, r_aux_idx, n_aux_idx;
    logic [tlsf_pkg::IDX_W-1:0]    r_pp_idx, n_pp_idx, r_pp_val, n_pp_val;
    logic [tlsf_pkg::FL_COUNT-1:0] r_flmap, n_flmap;
    logic [tlsf_pkg::SL_COUNT-1:0] r_slmap [tlsf_pkg::FL_COUNT];
    logic [tlsf_pkg::SL_COUNT-1:0] n_slmap [tlsf_pkg::FL_COUNT];
    logic                          r_ovalid, n_ovalid;
    logic [tlsf_pkg::OFF_W-1:0]    r_opay, n_opay, r_pay, n_pay;
    tlsf_pkg::t_status             r_ostat, n_ostat, r_st, n_st;

    logic                          hw_we, hr_re, lw_we, lr_re;
    logic [tlsf_pkg::IDX_W-1:0]    hw_addr, hr_addr;
    tlsf_pkg::t_hdr                hw_data, hr_data;
    logic [tlsf_pkg::HEAD_AW-1:0]  lw_addr, lr_addr;
    logic [tlsf_pkg::IDX_W-1:0]    lw_data, lr_data;
    logic [tlsf_pkg::HDR_W-1:0]    hr_raw;

    tlsf_pkg::t_cls                aux_cls;
    logic [tlsf_pkg::HEAD_AW-1:0]  aux_head;
    logic [tlsf_pkg::FL_W-1:0]     map_idx;
    logic [tlsf_pkg::SL_COUNT-1:0] map_row;
    logic                          in_acc, cfg_wr;

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign cfg_wr   = i_psel && i_penable && i_pwrite && o_pready;
    assign aux_cls  = tlsf_pkg::map_size(tlsf_pkg::B_W'(r_aux.size));
    assign aux_head = tlsf_pkg::head_addr(aux_cls);
    assign map_row  = r_slmap[map_idx];
    assign hr_data  = tlsf_pkg::t_hdr'(hr_raw);

    tlsf_ram #(
        .WIDTH (tlsf_pkg::HDR_W),
        .DEPTH (tlsf_pkg::NBLK)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (hw_we),
        .i_waddr (hw_addr),
        .i_wdata (hw_data),
        .i_re    (hr_re),
        .i_raddr (hr_addr),
        .o_rdata (hr_raw)
    );

    tlsf_ram #(
        .WIDTH (tlsf_pkg::IDX_W),
        .DEPTH (tlsf_pkg::HEAD_DEPTH)
    ) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (lw_we),
        .i_waddr (lw_addr),
        .i_wdata (lw_data),
        .i_re    (lr_re),
        .i_raddr (lr_addr),
        .o_rdata (lr_data)
    );

    always_comb begin
        tlsf_pkg::t_hdr                tmp;
        tlsf_pkg::t_hdr                nh;
        logic [tlsf_pkg::B_W-1:0]      b0;
        logic [tlsf_pkg::B_W-1:0]      msk;
        logic [tlsf_pkg::B_W-1:0]      rem;
        logic [tlsf_pkg::FL_W-1:0]     m;
        logic [tlsf_pkg::SL_COUNT-1:0] bits;
        logic [tlsf_pkg::FL_COUNT-1:0] fbits;
        logic [tlsf_pkg::SL_COUNT-1:0] row_new;
        logic [tlsf_pkg::OFF_W-1:0]    offw;
        logic [tlsf_pkg::IDX_W-1:0]    nidx;
        logic                          split;

        n_state   = r_state;
        n_ret     = r_ret;
        n_pret    = r_pret;
        n_clr     = r_clr;
        n_req     = r_req;
        n_b       = r_b;
        n_cls     = r_cls;
        n_f       = r_f;
        n_s       = r_s;
        n_cur     = r_cur;
        n_aux     = r_aux;
        n_cur_idx = r_cur_idx;
        n_aux_idx = r_aux_idx;
        n_pp_idx  = r_pp_idx;
        n_pp_val  = r_pp_val;
        n_flmap   = r_flmap;
        n_slmap   = r_slmap;
        n_pay     = r_pay;
        n_st      = r_st;
        n_ovalid  = r_ovalid && !i_m_axis_tready;
        n_opay    = r_opay;
        n_ostat   = r_ostat;

        hw_we   = 1'b0;
        hw_addr = r_aux_idx;
        hw_data = r_aux;
        hr_re   = 1'b0;
        hr_addr = r_aux_idx;
        lw_we   = 1'b0;
        lw_addr = aux_head;
        lw_data = '0;
        lr_re   = 1'b0;
        lr_addr = aux_head;
        map_idx = aux_cls.fl;

        tmp     = r_aux;
        nh      = '0;
        b0      = '0;
        msk     = '0;
        rem     = '0;
        m       = '0;
        bits    = '0;
        fbits   = '0;
        row_new = '0;
        offw    = '0;
        nidx    = '0;
        split   = 1'b0;

        case (r_state)
            S_CLEAR: begin
                tmp = '0;
                if (r_clr == '0) begin
                    tmp.valid   = 1'b1;
                    tmp.is_free = 1'b1;
                    tmp.is_last = 1'b1;
                    tmp.size    = tlsf_pkg::SIZE_W'(tlsf_pkg::NBLK * tlsf_pkg::GRANULE_BYTES
                                                    - tlsf_pkg::SPAN);
                    lw_we   = 1'b1;
                    lw_addr = tlsf_pkg::head_addr(tlsf_pkg::INIT_CLS);
                    lw_data = '0;
                end
                hw_we   = 1'b1;
                hw_addr = r_clr;
                hw_data = tmp;
                n_clr   = r_clr + 1'b1;
                if (r_clr == tlsf_pkg::IDX_W'(tlsf_pkg::NBLK - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_pay = '0;
                    n_st  = tlsf_pkg::ST_OK;
                    if (i_s_axis_tuser == tlsf_pkg::CMD_ALLOC) begin
                        n_req   = i_s_axis_tdata[15:0];
                        n_state = S_A_ROUND;
                    end else begin
                        offw = i_s_axis_tdata[31:16] - tlsf_pkg::OFF_W'(tlsf_pkg::SPAN);
                        if (i_s_axis_tdata[31:16] < tlsf_pkg::OFF_W'(tlsf_pkg::SPAN) ||
                            i_s_axis_tdata[16 +: tlsf_pkg::GRAN_LOG2] != '0 ||
                            (tlsf_pkg::B_W'(offw >> tlsf_pkg::GRAN_LOG2) >=
                             tlsf_pkg::B_W'(tlsf_pkg::NBLK))) begin
                            n_st    = tlsf_pkg::ST_BADFREE;
                            n_state = S_RESP;
                        end else begin
                            hr_re     = 1'b1;
                            hr_addr   = tlsf_pkg::IDX_W'(offw >> tlsf_pkg::GRAN_LOG2);
                            n_cur_idx = hr_addr;
                            n_state   = S_F_HDR;
                        end
                    end
                end
            end
            S_A_ROUND: begin
                if (r_req == '0) begin
                    n_st    = tlsf_pkg::ST_ZERO;
                    n_state = S_RESP;
                end else begin
                    b0 = (r_req < tlsf_pkg::OFF_W'(tlsf_pkg::SL_COUNT))
                         ? tlsf_pkg::B_W'(tlsf_pkg::SL_COUNT) : tlsf_pkg::B_W'(r_req);
                    n_b = (b0 + tlsf_pkg::B_W'(tlsf_pkg::GRANULE_BYTES - 1)) &
                          ~tlsf_pkg::B_W'(tlsf_pkg::GRANULE_BYTES - 1);
                    n_state = S_A_CLASS;
                end
            end
            S_A_CLASS: begin
                // round up to the start of a second-level class
                m   = tlsf_pkg::top_bit(r_b);
                msk = (tlsf_pkg::B_W'(1) << (m - tlsf_pkg::FL_W'(tlsf_pkg::SL_LOG2)))
                      - tlsf_pkg::B_W'(1);
                n_b = (r_b + msk) & ~msk;
                n_state = S_A_MAP;
            end
            S_A_MAP: begin
                n_cls = tlsf_pkg::map_size(r_b);
                if (n_cls.fl >= tlsf_pkg::FL_W'(tlsf_pkg::FL_COUNT)) begin
                    n_st    = tlsf_pkg::ST_OOM;
                    n_state = S_RESP;
                end else begin
                    n_state = S_A_SRCH1;
                end
            end
            S_A_SRCH1: begin
                map_idx = r_cls.fl;
                bits    = map_row & ({tlsf_pkg::SL_COUNT{1'b1}} << r_cls.sl);
                if (bits != '0) begin
                    n_f     = r_cls.fl;
                    n_s     = tlsf_pkg::low_bit_sl(bits);
                    n_state = S_A_HEAD;
                end else begin
                    fbits = r_flmap & ({tlsf_pkg::FL_COUNT{1'b1}} <<
                                       ({1'b0, r_cls.fl} + 1'b1));
                    if (fbits == '0) begin
                        n_st    = tlsf_pkg::ST_OOM;
                        n_state = S_RESP;
                    end else begin
                        n_f     = tlsf_pkg::low_bit_fl(fbits);
                        n_state = S_A_SRCH2;
                    end
                end
            end
            S_A_SRCH2: begin
                map_idx = r_f;
                if (map_row == '0) begin
                    n_st    = tlsf_pkg::ST_OOM;
                    n_state = S_RESP;
                end else begin
                    n_s     = tlsf_pkg::low_bit_sl(map_row);
                    n_state = S_A_HEAD;
                end
            end
            S_A_HEAD: begin
                lr_re   = 1'b1;
                lr_addr = tlsf_pkg::head_addr('{fl: r_f, sl: r_s});
                n_state = S_A_HWAIT;
            end
            S_A_HWAIT: begin
                hr_re     = 1'b1;
                hr_addr   = lr_data;
                n_aux_idx = lr_data;
                n_cur_idx = lr_data;
                n_state   = S_A_HDR;
            end
            S_A_HDR: begin
                n_aux = hr_data;
                if (tlsf_pkg::B_W'(hr_data.size) < r_b) begin
                    n_st    = tlsf_pkg::ST_OOM;
                    n_state = S_RESP;
                end else begin
                    n_ret   = S_A_SPLIT;
                    n_state = S_U_HEAD;
                end
            end
            S_A_SPLIT: begin
                rem   = tlsf_pkg::B_W'(r_aux.size) - r_b;
                split = (rem > tlsf_pkg::B_W'(r_thr)) && (rem > tlsf_pkg::B_W'(tlsf_pkg::SPAN));
                if (split) begin
                    nidx = r_aux_idx + tlsf_pkg::IDX_W'((r_b + tlsf_pkg::B_W'(tlsf_pkg::SPAN))
                                                        >> tlsf_pkg::GRAN_LOG2);
                    nh               = '0;
                    nh.valid         = 1'b1;
                    nh.size          = tlsf_pkg::SIZE_W'(rem - tlsf_pkg::B_W'(tlsf_pkg::SPAN));
                    nh.is_last       = r_aux.is_last;
                    nh.has_prev_phys = 1'b1;
                    nh.prev_phys     = r_aux_idx;
                    tmp              = r_aux;
                    tmp.size         = tlsf_pkg::SIZE_W'(r_b);
                    tmp.is_last      = 1'b0;
                    n_cur            = tmp;
                    n_aux            = nh;
                    n_aux_idx        = nidx;
                    n_ret            = S_A_DONE;
                    if (!r_aux.is_last) begin
                        n_pp_idx = tlsf_pkg::phys_succ(r_aux_idx, r_aux.size);
                        n_pp_val = nidx;
                        n_pret   = S_L_HEAD;
                        n_state  = S_P_RD;
                    end else begin
                        n_state = S_L_HEAD;
                    end
                end else begin
                    n_cur   = r_aux;
                    n_state = S_A_DONE;
                end
            end
            S_A_DONE: begin
                hw_we   = 1'b1;
                hw_addr = r_cur_idx;
                hw_data = r_cur;
                n_pay   = tlsf_pkg::OFF_W'({r_cur_idx, {tlsf_pkg::GRAN_LOG2{1'b0}}})
                          + tlsf_pkg::OFF_W'(tlsf_pkg::SPAN);
                n_st    = tlsf_pkg::ST_OK;
                n_state = S_RESP;
            end
            S_F_HDR: begin
                n_cur = hr_data;
                if (!hr_data.valid || hr_data.is_free) begin
                    n_st    = tlsf_pkg::ST_BADFREE;
                    n_state = S_RESP;
                end else if (hr_data.has_prev_phys) begin
                    hr_re     = 1'b1;
                    hr_addr   = hr_data.prev_phys;
                    n_aux_idx = hr_data.prev_phys;
                    n_state   = S_F_PHDR;
                end else begin
                    n_state = S_F_NXT;
                end
            end
            S_F_PHDR: begin
                if (hr_data.valid && hr_data.is_free) begin
                    n_aux   = hr_data;
                    n_ret   = S_F_PMRG;
                    n_state = S_U_HEAD;
                end else begin
                    n_state = S_F_NXT;
                end
            end
            S_F_PMRG: begin
                // previous neighbor swallows the freed block
                tmp         = r_aux;
                tmp.size    = r_aux.size + tlsf_pkg::SIZE_W'(tlsf_pkg::SPAN) + r_cur.size;
                tmp.is_last = r_cur.is_last;
                n_aux       = tmp;
                if (!r_cur.is_last) begin
                    n_pp_idx = tlsf_pkg::phys_succ(r_cur_idx, r_cur.size);
                    n_pp_val = r_aux_idx;
                    n_pret   = S_F_PZERO;
                    n_state  = S_P_RD;
                end else begin
                    n_state = S_F_PZERO;
                end
            end
            S_F_PZERO: begin
                hw_we     = 1'b1;
                hw_addr   = r_cur_idx;
                hw_data   = '0;
                n_cur     = r_aux;
                n_cur_idx = r_aux_idx;
                n_state   = S_F_NXT;
            end
            S_F_NXT: begin
                if (!r_cur.is_last) begin
                    hr_re     = 1'b1;
                    hr_addr   = tlsf_pkg::phys_succ(r_cur_idx, r_cur.size);
                    n_aux_idx = hr_addr;
                    n_state   = S_F_NHDR;
                end else begin
                    n_state = S_F_LINK;
                end
            end
            S_F_NHDR: begin
                if (hr_data.valid && hr_data.is_free) begin
                    n_aux   = hr_data;
                    n_ret   = S_F_NMRG;
                    n_state = S_U_HEAD;
                end else begin
                    n_state = S_F_LINK;
                end
            end
            S_F_NMRG: begin
                tmp         = r_cur;
                tmp.size    = r_cur.size + tlsf_pkg::SIZE_W'(tlsf_pkg::SPAN) + r_aux.size;
                tmp.is_last = r_aux.is_last;
                n_cur       = tmp;
                if (!r_aux.is_last) begin
                    n_pp_idx = tlsf_pkg::phys_succ(r_aux_idx, r_aux.size);
                    n_pp_val = r_cur_idx;
                    n_pret   = S_F_NZERO;
                    n_state  = S_P_RD;
                end else begin
                    n_state = S_F_NZERO;
                end
            end
            S_F_NZERO: begin
                hw_we   = 1'b1;
                hw_addr = r_aux_idx;
                hw_data = '0;
                n_state = S_F_LINK;
            end
            S_F_LINK: begin
                n_aux     = r_cur;
                n_aux_idx = r_cur_idx;
                n_st      = tlsf_pkg::ST_OK;
                n_ret     = S_RESP;
                n_state   = S_L_HEAD;
            end
            // unlink the block held in r_aux from its free list
            S_U_HEAD: begin
                lr_re   = 1'b1;
                n_state = S_U_HCHK;
            end
            S_U_HCHK: begin
                if (map_row[aux_cls.sl] && lr_data == r_aux_idx) begin
                    lw_we   = 1'b1;
                    lw_data = r_aux.has_next_free ? r_aux.next_free : '0;
                    if (!r_aux.has_next_free) begin
                        row_new = map_row & ~(tlsf_pkg::SL_COUNT'(1) << aux_cls.sl);
                        n_slmap[aux_cls.fl] = row_new;
                        if (row_new == '0) begin
                            n_flmap[aux_cls.fl] = 1'b0;
                        end
                    end
                end
                if (r_aux.has_next_free) begin
                    hr_re   = 1'b1;
                    hr_addr = r_aux.next_free;
                    n_state = S_U_NWR;
                end else if (r_aux.has_prev_free) begin
                    hr_re   = 1'b1;
                    hr_addr = r_aux.prev_free;
                    n_state = S_U_PWR;
                end else begin
                    n_state = S_U_END;
                end
            end
            S_U_NWR: begin
                tmp               = hr_data;
                tmp.has_prev_free = r_aux.has_prev_free;
                tmp.prev_free     = r_aux.prev_free;
                hw_we             = 1'b1;
                hw_addr           = r_aux.next_free;
                hw_data           = tmp;
                if (r_aux.has_prev_free) begin
                    hr_re   = 1'b1;
                    hr_addr = r_aux.prev_free;
                    n_state = S_U_PWR;
                end else begin
                    n_state = S_U_END;
                end
            end
            S_U_PWR: begin
                tmp               = hr_data;
                tmp.has_next_free = r_aux.has_next_free;
                tmp.next_free     = r_aux.next_free;
                hw_we             = 1'b1;
                hw_addr           = r_aux.prev_free;
                hw_data           = tmp;
                n_state           = S_U_END;
            end
            S_U_END: begin
                tmp               = r_aux;
                tmp.has_next_free = 1'b0;
                tmp.has_prev_free = 1'b0;
                tmp.next_free     = '0;
                tmp.prev_free     = '0;
                tmp.is_free       = 1'b0;
                n_aux             = tmp;
                n_state           = r_ret;
            end
            // push the block held in r_aux onto the head of its free list
            S_L_HEAD: begin
                lr_re   = 1'b1;
                n_state = S_L_HCHK;
            end
            S_L_HCHK: begin
                tmp               = r_aux;
                tmp.has_prev_free = 1'b0;
                tmp.prev_free     = '0;
                tmp.has_next_free = map_row[aux_cls.sl];
                tmp.next_free     = map_row[aux_cls.sl] ? lr_data : '0;
                tmp.is_free       = 1'b1;
                n_aux             = tmp;
                lw_we             = 1'b1;
                lw_data           = r_aux_idx;
                n_slmap[aux_cls.fl][aux_cls.sl] = 1'b1;
                n_flmap[aux_cls.fl]             = 1'b1;
                if (map_row[aux_cls.sl]) begin
                    hr_re   = 1'b1;
                    hr_addr = lr_data;
                    n_state = S_L_NWR;
                end else begin
                    n_state = S_L_WR;
                end
            end
            S_L_NWR: begin
                tmp               = hr_data;
                tmp.has_prev_free = 1'b1;
                tmp.prev_free     = r_aux_idx;
                hw_we             = 1'b1;
                hw_addr           = r_aux.next_free;
                hw_data           = tmp;
                n_state           = S_L_WR;
            end
            S_L_WR: begin
                hw_we   = 1'b1;
                n_state = r_ret;
            end
            // point a physical successor back at its new predecessor
            S_P_RD: begin
                hr_re   = 1'b1;
                hr_addr = r_pp_idx;
                n_state = S_P_WR;
            end
            S_P_WR: begin
                tmp               = hr_data;
                tmp.has_prev_phys = 1'b1;
                tmp.prev_phys     = r_pp_val;
                hw_we             = 1'b1;
                hw_addr           = r_pp_idx;
                hw_data           = tmp;
                n_state           = r_pret;
            end
            S_RESP: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_opay   = (r_st == tlsf_pkg::ST_OK) ? r_pay : '0;
                    n_ostat  = r_st;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_ret    <= S_IDLE;
            r_pret   <= S_IDLE;
            r_clr    <= '0;
            r_thr    <= tlsf_pkg::THR_W'(tlsf_pkg::THR_RESET);
            r_ovalid <= 1'b0;
            r_flmap  <= tlsf_pkg::FL_COUNT'(1) << tlsf_pkg::INIT_CLS.fl;
            for (int i = 0; i < tlsf_pkg::FL_COUNT; i++) begin
                r_slmap[i] <= (i == int'(tlsf_pkg::INIT_CLS.fl))
                              ? (tlsf_pkg::SL_COUNT'(1) << tlsf_pkg::INIT_CLS.sl) : '0;
            end
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_pret   <= n_pret;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
            r_flmap  <= n_flmap;
            r_slmap  <= n_slmap;
            if (cfg_wr && i_paddr[2] == 1'b0) begin
                r_thr <= i_pwdata[tlsf_pkg::THR_W-1:0];
            end
        end
        r_req     <= n_req;
        r_b       <= n_b;
        r_cls     <= n_cls;
        r_f       <= n_f;
        r_s       <= n_s;
        r_cur     <= n_cur;
        r_aux     <= n_aux;
        r_cur_idx <= n_cur_idx;
        r_aux_idx <= n_aux_idx;
        r_pp_idx  <= n_pp_idx;
        r_pp_val  <= n_pp_val;
        r_pay     <= n_pay;
        r_st      <= n_st;
        r_opay    <= n_opay;
        r_ostat   <= n_ostat;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {6'd0, r_ostat, r_opay};
    assign o_pready        = 1'b1;
    assign o_prdata        = (i_paddr[2] == 1'b0)
                             ? {{(32 - tlsf_pkg::THR_W){1'b0}}, r_thr} : 32'd0;

`ifndef NO_ASSERTIONS
    logic [tlsf_pkg::FL_COUNT-1:0] sl_any;

    always_comb begin
        for (int i = 0; i < tlsf_pkg::FL_COUNT; i++) begin
            sl_any[i] = |r_slmap[i];
        end
    end

    // first-level bit mirrors whether any second-level bit of that row is set
    a_map_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flmap == sl_any)
        else $error("first-level map out of step with second-level maps");

    // no header read collides with a write to the same entry
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (hw_we && hr_re) |-> (hw_addr != hr_addr))
        else $error("header ram read and write to the same entry");

    // only an ok allocate carries a nonzero offset
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ostat != tlsf_pkg::ST_OK) |-> (r_opay == '0))
        else $error("payload offset nonzero on a failed request");

    // the clearing pass finishes before any word is taken
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_s_axis_tready)
        else $error("input accepted during clearing pass");
`endif

endmodule
